// ===== rtl/pst_pkg.sv =====
// Shared types, constants and saturating arithmetic for the P-Delta
// stiffness transform core. No dependencies.
package pst_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int FRAC_BITS   = 32;
  localparam int HALF_WIDTH  = VALUE_WIDTH / 2;

  localparam int NUM_IN_VALS  = 10;
  localparam int NUM_COLS     = 6;
  localparam int IN_W         = NUM_IN_VALS * VALUE_WIDTH;
  localparam int OUT_W        = NUM_COLS * VALUE_WIDTH;

  localparam int CFG_ADDR_W   = 6;
  localparam int CFG_DATA_W   = 64;
  localparam int DIR_W        = 34;
  localparam int INVL_W       = 63;

  typedef logic signed [VALUE_WIDTH-1:0] val_t;
  typedef logic [2:0] row_t;

  localparam val_t VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  localparam row_t ROW_LAST  = 3'd5;
  localparam row_t ROW_GROUP = 3'd3;

  function automatic val_t sat_add(val_t a, val_t b);
    logic [VALUE_WIDTH:0] s;
    s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
    if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
      return s[VALUE_WIDTH] ? VAL_MIN : VAL_MAX;
    end
    return val_t'(s[VALUE_WIDTH-1:0]);
  endfunction

  function automatic val_t sat_sub(val_t a, val_t b);
    logic [VALUE_WIDTH:0] s;
    s = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
    if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
      return s[VALUE_WIDTH] ? VAL_MIN : VAL_MAX;
    end
    return val_t'(s[VALUE_WIDTH-1:0]);
  endfunction

  function automatic val_t sat_neg(val_t a);
    return (a == VAL_MIN) ? VAL_MAX : val_t'(-a);
  endfunction

  // two saturating negations in a row
  function automatic val_t neg_neg(val_t a);
    return (a == VAL_MIN) ? val_t'(VAL_MIN + val_t'(1)) : a;
  endfunction

endpackage

// ===== rtl/pdelta_stiffness_transform_2d_core.sv =====
// P-Delta planar frame stiffness transform, top level.
// Depends on pst_pkg, pst_lane and pst_mul.
//
//  channel | dir | transfer                      | payload
//  in_     | in  | one 3x3 basic stiffness + N   | tdata: stiff_00..22, axial_force
//  out_    | out | one row of global 6x6 matrix  | tdata: col_0..5, tuser: row_index
//  cfg_    | in  | register write / read         | 64-bit data, regs at 8*i
//
// Six output transfers per input item; sustained throughput is set by the
// single output row per cycle while out_tready is high. From input transfer
// to the first row lie 7 front stages, the row issue register and two
// 5-stage lane rows.
// Reset is synchronous; no clearing pass. A stalled output holds the
// whole row pipeline; the front keeps filling until its last stage waits.
module pdelta_stiffness_transform_2d_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pst_pkg::IN_W-1:0]            in_tdata,   // stiff_00..stiff_22, axial_force
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pst_pkg::OUT_W-1:0]           out_tdata,  // col_0..col_5
  output logic [2:0]                          out_tuser,  // row_index
  output logic                                out_tlast,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [pst_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [pst_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [pst_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);
  import pst_pkg::*;

  typedef enum logic [1:0] {KIND_ROT_A, KIND_ROT_B, KIND_OFFS} kind_t;

  localparam logic [2:0] REG_COS  = 3'd0;
  localparam logic [2:0] REG_SIN  = 3'd1;
  localparam logic [2:0] REG_INVL = 3'd2;
  localparam logic [2:0] REG_OIX  = 3'd3;
  localparam logic [2:0] REG_OIY  = 3'd4;
  localparam logic [2:0] REG_OJX  = 3'd5;
  localparam logic [2:0] REG_OJY  = 3'd6;

  // basic stiffness sums: a=k10+k20 b=k01+k02 c=k11+k12 d=k21+k22 e=k11+k21 f=k12+k22
  localparam int SUM_L [6] = '{3, 1, 4, 7, 4, 5};
  localparam int SUM_R [6] = '{6, 2, 5, 8, 7, 8};

  // ---------------- configuration ----------------
  logic [DIR_W-1:0]  cos_r, sin_r;
  logic [INVL_W-1:0] invl_r;
  val_t              ofs_r [4];
  logic              cfg_wr;
  logic [2:0]        cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r  <= DIR_W'(1) << FRAC_BITS;
      sin_r  <= '0;
      invl_r <= INVL_W'(1) << FRAC_BITS;
      ofs_r  <= '{default: '0};
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_COS:  cos_r    <= cfg_pwdata[DIR_W-1:0];
        REG_SIN:  sin_r    <= cfg_pwdata[DIR_W-1:0];
        REG_INVL: invl_r   <= cfg_pwdata[INVL_W-1:0];
        REG_OIX:  ofs_r[0] <= val_t'(cfg_pwdata);
        REG_OIY:  ofs_r[1] <= val_t'(cfg_pwdata);
        REG_OJX:  ofs_r[2] <= val_t'(cfg_pwdata);
        REG_OJY:  ofs_r[3] <= val_t'(cfg_pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_COS:  cfg_prdata = CFG_DATA_W'(cos_r);
      REG_SIN:  cfg_prdata = CFG_DATA_W'(sin_r);
      REG_INVL: cfg_prdata = CFG_DATA_W'(invl_r);
      REG_OIX:  cfg_prdata = CFG_DATA_W'(ofs_r[0]);
      REG_OIY:  cfg_prdata = CFG_DATA_W'(ofs_r[1]);
      REG_OJX:  cfg_prdata = CFG_DATA_W'(ofs_r[2]);
      REG_OJY:  cfg_prdata = CFG_DATA_W'(ofs_r[3]);
      default:  cfg_prdata = '0;
    endcase
  end

  val_t c_v, sn_v, s_v;
  assign c_v  = val_t'($signed(cos_r));
  assign sn_v = val_t'($signed(sin_r));
  assign s_v  = val_t'({1'b0, invl_r});

  // config-derived terms, free running: s*s and the offset terms
  val_t ss_q;
  val_t tp_q [2][4];
  val_t t_r [4];    // ti0, ti1, tj0, tj1

  pst_mul u_ss (.clk(clk), .en(1'b1), .a_i(s_v), .b_i(s_v), .p_o(ss_q));

  for (genvar e = 0; e < 2; e++) begin : g_ofs
    pst_mul u_t0 (.clk(clk), .en(1'b1), .a_i(sn_v), .b_i(ofs_r[2*e]),   .p_o(tp_q[e][0]));
    pst_mul u_t1 (.clk(clk), .en(1'b1), .a_i(c_v),  .b_i(ofs_r[2*e+1]), .p_o(tp_q[e][1]));
    pst_mul u_t2 (.clk(clk), .en(1'b1), .a_i(sn_v), .b_i(ofs_r[2*e+1]), .p_o(tp_q[e][2]));
    pst_mul u_t3 (.clk(clk), .en(1'b1), .a_i(c_v),  .b_i(ofs_r[2*e]),   .p_o(tp_q[e][3]));
  end

  always_ff @(posedge clk) begin
    for (int e = 0; e < 2; e++) begin
      t_r[2*e]   <= sat_sub(tp_q[e][0], tp_q[e][1]);
      t_r[2*e+1] <= sat_add(tp_q[e][2], tp_q[e][3]);
    end
  end

  // ---------------- front: local stiffness per item ----------------
  logic [6:0] fv_r;
  logic       fe, load, adv;
  val_t       k_in [9];
  val_t       p_in;
  val_t       k1_r [9], k2_r [9], k3_r [9];
  val_t       p1_r, p2_r, p3_r;
  val_t       sum1_r [6], sum2_r [6], sum3_r [6];
  val_t       s3_r, s4_r;
  val_t       kd_r [3][9];
  val_t       m_q [6];
  val_t       nl_q, pre_q;
  val_t       kl1_r [6][6], kl1_nxt [6][6];
  val_t       nl1_r;

  for (genvar i = 0; i < 9; i++) begin : g_kin
    assign k_in[i] = val_t'(in_tdata[i*VALUE_WIDTH +: VALUE_WIDTH]);
  end
  assign p_in = val_t'(in_tdata[9*VALUE_WIDTH +: VALUE_WIDTH]);

  assign fe        = !fv_r[6] || load;
  assign in_tready = fe;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else if (fe) begin
      fv_r <= {fv_r[5:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      k1_r  <= k_in;
      p1_r  <= p_in;
      for (int i = 0; i < 6; i++) begin
        sum1_r[i] <= sat_add(k_in[SUM_L[i]], k_in[SUM_R[i]]);
      end
      k2_r   <= k1_r;
      p2_r   <= p1_r;
      sum2_r <= sum1_r;
      s3_r   <= sat_add(sum1_r[2], k1_r[7]);
      k3_r   <= k2_r;
      p3_r   <= p2_r;
      sum3_r <= sum2_r;
      s4_r   <= sat_add(s3_r, k2_r[8]);
      kd_r[0] <= k3_r;
      kd_r[1] <= kd_r[0];
      kd_r[2] <= kd_r[1];
      kl1_r  <= kl1_nxt;
      nl1_r  <= nl_q;
    end
  end

  for (genvar i = 0; i < 6; i++) begin : g_msum
    pst_mul u_m (.clk(clk), .en(fe), .a_i(s_v), .b_i(sum3_r[i]), .p_o(m_q[i]));
  end
  pst_mul u_nl  (.clk(clk), .en(fe), .a_i(p3_r), .b_i(s_v),  .p_o(nl_q));
  pst_mul u_pre (.clk(clk), .en(fe), .a_i(ss_q), .b_i(s4_r), .p_o(pre_q));

  // entries [1][1], [1][4], [4][1], [4][4] get the axial term on issue
  always_comb begin
    kl1_nxt[0] = '{kd_r[2][0], sat_neg(m_q[1]), sat_neg(kd_r[2][1]),
                   sat_neg(kd_r[2][0]), neg_neg(m_q[1]), sat_neg(kd_r[2][2])};
    kl1_nxt[1] = '{sat_neg(m_q[0]), pre_q, m_q[4],
                   neg_neg(m_q[0]), sat_neg(pre_q), m_q[5]};
    kl1_nxt[2] = '{sat_neg(kd_r[2][3]), m_q[2], kd_r[2][4],
                   neg_neg(kd_r[2][3]), sat_neg(m_q[2]), kd_r[2][5]};
    kl1_nxt[3] = '{sat_neg(kd_r[2][0]), neg_neg(m_q[1]), kd_r[2][1],
                   neg_neg(kd_r[2][0]), sat_neg(m_q[1]), kd_r[2][2]};
    kl1_nxt[4] = '{neg_neg(m_q[0]), sat_neg(pre_q), sat_neg(m_q[4]),
                   sat_neg(m_q[0]), neg_neg(pre_q), sat_neg(m_q[5])};
    kl1_nxt[5] = '{sat_neg(kd_r[2][6]), m_q[3], kd_r[2][7],
                   neg_neg(kd_r[2][6]), sat_neg(m_q[3]), kd_r[2][8]};
  end

  // ---------------- row issue ----------------
  logic iss_v_r;
  row_t row_r;
  val_t kl_r [6][6], kl_ld [6][6];

  assign load = adv && (!iss_v_r || row_r == ROW_LAST);

  always_comb begin
    kl_ld       = kl1_r;
    kl_ld[1][1] = sat_add(kl1_r[1][1], nl1_r);
    kl_ld[1][4] = sat_sub(kl1_r[1][4], nl1_r);
    kl_ld[4][1] = sat_sub(kl1_r[4][1], nl1_r);
    kl_ld[4][4] = sat_add(kl1_r[4][4], nl1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_v_r <= 1'b0;
      row_r   <= '0;
    end else if (load) begin
      iss_v_r <= fv_r[6];
      row_r   <= '0;
    end else if (adv && iss_v_r) begin
      row_r   <= row_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kl_r <= kl_ld;
    end
  end

  // ---------------- row pipeline ----------------
  logic [9:0] vp_r;
  row_t       rp_r [10];
  logic       grp, grp2;
  kind_t      kind;
  val_t       tm_q [3][6];
  val_t       kg_q [6];

  assign adv  = !vp_r[9] || out_tready;
  assign grp  = row_r >= ROW_GROUP;
  assign grp2 = rp_r[4] >= ROW_GROUP;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= '0;
    end else if (adv) begin
      vp_r <= {vp_r[8:0], iss_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rp_r[0] <= row_r;
      for (int i = 1; i < 10; i++) begin
        rp_r[i] <= rp_r[i-1];
      end
    end
  end

  // T applied to three local rows of the group
  for (genvar q = 0; q < 3; q++) begin : g_tr
    for (genvar j = 0; j < 6; j++) begin : g_tc
      localparam int B = (j / 3) * 3;
      localparam int K = j % 3;
      val_t lx, ly, lz, lcx, lcy;
      assign lx  = grp ? kl_r[q+3][B]   : kl_r[q][B];
      assign ly  = grp ? kl_r[q+3][B+1] : kl_r[q][B+1];
      assign lz  = (K == 2) ? (grp ? kl_r[q+3][B+2] : kl_r[q][B+2]) : '0;
      assign lcx = (K == 0) ? c_v  : (K == 1) ? sn_v : t_r[B == 0 ? 0 : 2];
      assign lcy = (K == 0) ? sn_v : (K == 1) ? c_v  : t_r[B == 0 ? 1 : 3];
      pst_lane u_lane (
        .clk(clk), .en(adv), .x_i(lx), .y_i(ly), .cx_i(lcx), .cy_i(lcy),
        .z_i(lz), .sub_i(K == 0), .q_o(tm_q[q][j])
      );
    end
  end

  always_comb begin
    case (rp_r[4])
      3'd0, 3'd3: kind = KIND_ROT_A;
      3'd1, 3'd4: kind = KIND_ROT_B;
      default:    kind = KIND_OFFS;
    endcase
  end

  // T' applied down each column
  for (genvar j = 0; j < 6; j++) begin : g_kg
    val_t gz, gcx, gcy;
    always_comb begin
      case (kind)
        KIND_ROT_A: begin
          gcx = c_v;
          gcy = sn_v;
          gz  = '0;
        end
        KIND_ROT_B: begin
          gcx = sn_v;
          gcy = c_v;
          gz  = '0;
        end
        default: begin
          gcx = grp2 ? t_r[2] : t_r[0];
          gcy = grp2 ? t_r[3] : t_r[1];
          gz  = tm_q[2][j];
        end
      endcase
    end
    pst_lane u_lane (
      .clk(clk), .en(adv), .x_i(tm_q[0][j]), .y_i(tm_q[1][j]), .cx_i(gcx), .cy_i(gcy),
      .z_i(gz), .sub_i(kind == KIND_ROT_A), .q_o(kg_q[j])
    );
    assign out_tdata[j*VALUE_WIDTH +: VALUE_WIDTH] = kg_q[j];
  end

  assign out_tvalid = vp_r[9];
  assign out_tuser  = rp_r[9];
  assign out_tlast  = (rp_r[9] == ROW_LAST);

  // ---------------- checks ----------------
  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && iss_v_r && row_r != ROW_LAST) |=> (iss_v_r && row_r == $past(row_r) + 3'd1))
    else $error("row counter skipped a row");

  a_in_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> fv_r[0])
    else $error("input transfer not captured");

  a_out_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= ROW_LAST))
    else $error("row index out of range");

endmodule

// ===== rtl/pst_mul.sv =====
// Three-stage saturating Q-format multiplier, product split into
// half-width partial products. Depends on pst_pkg.
module pst_mul (
  input  logic          clk,
  input  logic          en,
  input  pst_pkg::val_t a_i,
  input  pst_pkg::val_t b_i,
  output pst_pkg::val_t p_o
);
  import pst_pkg::*;

  localparam int PW = 2 * VALUE_WIDTH;
  localparam int MW = PW - FRAC_BITS;
  localparam logic [PW-1:0] RND    = PW'(1) << (FRAC_BITS - 1);
  localparam logic [MW-1:0] MAGMIN = MW'(1) << (VALUE_WIDTH - 1);

  logic                   neg1_r, neg2_r;
  logic [VALUE_WIDTH-1:0] ua_r, ub_r, ua_nxt, ub_nxt;
  logic [VALUE_WIDTH-1:0] pp_r [4];
  logic [PW-1:0]          full;
  logic [MW-1:0]          mag;
  val_t                   p_r, p_nxt;

  assign ua_nxt = a_i[VALUE_WIDTH-1] ? VALUE_WIDTH'(-a_i) : VALUE_WIDTH'(a_i);
  assign ub_nxt = b_i[VALUE_WIDTH-1] ? VALUE_WIDTH'(-b_i) : VALUE_WIDTH'(b_i);

  always_comb begin
    full = PW'(pp_r[0]) + (PW'(pp_r[1]) << HALF_WIDTH) + (PW'(pp_r[2]) << HALF_WIDTH)
         + (PW'(pp_r[3]) << VALUE_WIDTH) + RND;
    mag  = full[PW-1:FRAC_BITS];
    if (!neg2_r) begin
      p_nxt = (|mag[MW-1:VALUE_WIDTH-1]) ? VAL_MAX : val_t'(mag[VALUE_WIDTH-1:0]);
    end else begin
      p_nxt = (mag > MAGMIN) ? VAL_MIN : val_t'(-mag[VALUE_WIDTH-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r  <= a_i[VALUE_WIDTH-1] ^ b_i[VALUE_WIDTH-1];
      ua_r    <= ua_nxt;
      ub_r    <= ub_nxt;
      neg2_r  <= neg1_r;
      pp_r[0] <= VALUE_WIDTH'(ua_r[HALF_WIDTH-1:0]) * VALUE_WIDTH'(ub_r[HALF_WIDTH-1:0]);
      pp_r[1] <= VALUE_WIDTH'(ua_r[HALF_WIDTH-1:0]) *
                 VALUE_WIDTH'(ub_r[VALUE_WIDTH-1:HALF_WIDTH]);
      pp_r[2] <= VALUE_WIDTH'(ua_r[VALUE_WIDTH-1:HALF_WIDTH]) *
                 VALUE_WIDTH'(ub_r[HALF_WIDTH-1:0]);
      pp_r[3] <= VALUE_WIDTH'(ua_r[VALUE_WIDTH-1:HALF_WIDTH]) *
                 VALUE_WIDTH'(ub_r[VALUE_WIDTH-1:HALF_WIDTH]);
      p_r     <= p_nxt;
    end
  end

  assign p_o = p_r;

endmodule

// ===== rtl/pst_lane.sv =====
// One transform lane, (x*cx +/- y*cy) + z, five register stages.
// Depends on pst_pkg and pst_mul.
module pst_lane (
  input  logic          clk,
  input  logic          en,
  input  pst_pkg::val_t x_i,
  input  pst_pkg::val_t y_i,
  input  pst_pkg::val_t cx_i,
  input  pst_pkg::val_t cy_i,
  input  pst_pkg::val_t z_i,
  input  logic          sub_i,
  output pst_pkg::val_t q_o
);
  import pst_pkg::*;

  val_t px, py;
  val_t z_r [3];
  logic sub_r [3];
  val_t s1_r, z4_r, q_r;

  pst_mul u_mx (.clk(clk), .en(en), .a_i(x_i), .b_i(cx_i), .p_o(px));
  pst_mul u_my (.clk(clk), .en(en), .a_i(y_i), .b_i(cy_i), .p_o(py));

  always_ff @(posedge clk) begin
    if (en) begin
      z_r[0]   <= z_i;
      z_r[1]   <= z_r[0];
      z_r[2]   <= z_r[1];
      sub_r[0] <= sub_i;
      sub_r[1] <= sub_r[0];
      sub_r[2] <= sub_r[1];
      s1_r     <= sub_r[2] ? sat_sub(px, py) : sat_add(px, py);
      z4_r     <= z_r[2];
      q_r      <= sat_add(s1_r, z4_r);
    end
  end

  assign q_o = q_r;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for pdelta_stiffness_transform_2d_core: random and directed
// stiffness items, several register settings, with the predicted global rows checked.
// Depends on pst_pkg and the core RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pst_pkg::*;

  typedef enum int {
    REG_COS = 0, REG_SIN = 1, REG_INVL = 2, REG_OIX = 3, REG_OIY = 4,
    REG_OJX = 5, REG_OJY = 6, REG_SPARE = 7
  } reg_idx_e;

  typedef struct {
    row_t idx;
    val_t col[6];
    logic last;
  } gk_row_t;

  class stiffness_board;
    logic [63:0] regs[7];
    gk_row_t rows_due[$];
    int errors;

    function new();
      regs[REG_COS] = 64'h1_0000_0000;
      regs[REG_SIN] = '0;
      regs[REG_INVL] = 64'h1_0000_0000;
      for (int i = 3; i < 7; i++) regs[i] = '0;
      errors = 0;
    endfunction

    function void write_reg(int idx, logic [63:0] v);
      if (idx == REG_COS || idx == REG_SIN) regs[idx] = {30'b0, v[33:0]};
      else if (idx == REG_INVL) regs[idx] = {1'b0, v[62:0]};
      else if (idx < 7) regs[idx] = v;
    endfunction

    function val_t add(val_t a, val_t b);
      logic signed [64:0] s;
      s = a + b;
      if (s > 65'sd9223372036854775807) return VAL_MAX;
      if (s < -65'sd9223372036854775808) return VAL_MIN;
      return s[63:0];
    endfunction

    function val_t sub(val_t a, val_t b);
      logic signed [64:0] s;
      s = a - b;
      if (s > 65'sd9223372036854775807) return VAL_MAX;
      if (s < -65'sd9223372036854775808) return VAL_MIN;
      return s[63:0];
    endfunction

    function val_t neg(val_t a);
      return sub('0, a);
    endfunction

    function val_t mul(val_t a, val_t b);
      logic [127:0] ua, ub, m;
      logic n;
      n = a[63] ^ b[63];
      ua = {64'b0, a[63] ? 64'(-a) : 64'(a)};
      ub = {64'b0, b[63] ? 64'(-b) : 64'(b)};
      m = ((ua * ub) + (128'd1 << 31)) >> 32;
      if (!n) return (m > 128'h7FFF_FFFF_FFFF_FFFF) ? VAL_MAX : val_t'(m[63:0]);
      if (m > 128'h8000_0000_0000_0000) return VAL_MIN;
      return val_t'(-m[63:0]);
    endfunction

    function void note_item(val_t k[9], val_t p);
      val_t c, sn, s, oix, oiy, ojx, ojy, nl, ti0, ti1, tj0, tj1;
      val_t kl[6][6], tm[6][6], kg[6][6];
      gk_row_t r;
      c = {{30{regs[REG_COS][33]}}, regs[REG_COS][33:0]};
      sn = {{30{regs[REG_SIN][33]}}, regs[REG_SIN][33:0]};
      s = regs[REG_INVL];
      oix = regs[REG_OIX]; oiy = regs[REG_OIY];
      ojx = regs[REG_OJX]; ojy = regs[REG_OJY];

      kl[0][0] = k[0];
      kl[1][0] = neg(mul(s, add(k[3], k[6])));
      kl[2][0] = neg(k[3]);
      kl[3][0] = neg(k[0]);
      kl[4][0] = neg(kl[1][0]);
      kl[5][0] = neg(k[6]);
      kl[0][1] = neg(mul(s, add(k[1], k[2])));
      kl[1][1] = mul(mul(s, s), add(add(add(k[4], k[5]), k[7]), k[8]));
      kl[2][1] = mul(s, add(k[4], k[5]));
      kl[3][1] = neg(kl[0][1]);
      kl[4][1] = neg(kl[1][1]);
      kl[5][1] = mul(s, add(k[7], k[8]));
      kl[0][2] = neg(k[1]);
      kl[1][2] = mul(s, add(k[4], k[7]));
      kl[2][2] = k[4];
      kl[3][2] = k[1];
      kl[4][2] = neg(kl[1][2]);
      kl[5][2] = k[7];
      for (int i = 0; i < 6; i++) begin
        kl[i][3] = neg(kl[i][0]);
        kl[i][4] = neg(kl[i][1]);
      end
      kl[0][5] = neg(k[2]);
      kl[1][5] = mul(s, add(k[5], k[8]));
      kl[2][5] = k[5];
      kl[3][5] = k[2];
      kl[4][5] = neg(kl[1][5]);
      kl[5][5] = k[8];

      nl = mul(p, s);
      kl[1][1] = add(kl[1][1], nl);
      kl[4][4] = add(kl[4][4], nl);
      kl[1][4] = sub(kl[1][4], nl);
      kl[4][1] = sub(kl[4][1], nl);

      ti0 = sub(mul(sn, oix), mul(c, oiy));
      ti1 = add(mul(sn, oiy), mul(c, oix));
      tj0 = sub(mul(sn, ojx), mul(c, ojy));
      tj1 = add(mul(sn, ojy), mul(c, ojx));

      for (int i = 0; i < 6; i++) begin
        tm[i][0] = sub(mul(kl[i][0], c), mul(kl[i][1], sn));
        tm[i][1] = add(mul(kl[i][0], sn), mul(kl[i][1], c));
        tm[i][2] = add(add(mul(kl[i][0], ti0), mul(kl[i][1], ti1)), kl[i][2]);
        tm[i][3] = sub(mul(kl[i][3], c), mul(kl[i][4], sn));
        tm[i][4] = add(mul(kl[i][3], sn), mul(kl[i][4], c));
        tm[i][5] = add(add(mul(kl[i][3], tj0), mul(kl[i][4], tj1)), kl[i][5]);
      end
      for (int j = 0; j < 6; j++) begin
        kg[0][j] = sub(mul(tm[0][j], c), mul(tm[1][j], sn));
        kg[1][j] = add(mul(tm[0][j], sn), mul(tm[1][j], c));
        kg[2][j] = add(add(mul(tm[0][j], ti0), mul(tm[1][j], ti1)), tm[2][j]);
        kg[3][j] = sub(mul(tm[3][j], c), mul(tm[4][j], sn));
        kg[4][j] = add(mul(tm[3][j], sn), mul(tm[4][j], c));
        kg[5][j] = add(add(mul(tm[3][j], tj0), mul(tm[4][j], tj1)), tm[5][j]);
      end
      for (int i = 0; i < 6; i++) begin
        r.idx = row_t'(i);
        for (int j = 0; j < 6; j++) r.col[j] = kg[i][j];
        r.last = (row_t'(i) == ROW_LAST);
        rows_due.push_back(r);
      end
    endfunction

    function void check_row(logic [OUT_W-1:0] data, logic [2:0] user, logic last);
      gk_row_t e;
      val_t got;
      if (rows_due.size() == 0) begin
        $display("%0t: unexpected row transfer, row %0d", $time, user);
        errors++;
        return;
      end
      e = rows_due.pop_front();
      if (user !== e.idx) begin
        $display("%0t: row_index expected %0d actual %0d", $time, e.idx, user);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last_row expected %0b actual %0b", $time, e.last, last);
        errors++;
      end
      for (int j = 0; j < 6; j++) begin
        got = data[j*64 +: 64];
        if (got !== e.col[j]) begin
          $display("%0t: row %0d col_%0d expected %h actual %h",
                   $time, e.idx, j, e.col[j], got);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_W-1:0] out_tdata;
  logic [2:0] out_tuser;
  logic out_tlast;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  pdelta_stiffness_transform_2d_core uut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  stiffness_board board = new();
  logic no_idle = 0;
  int cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_row(out_tdata, out_tuser, out_tlast);
    out_tready <= no_idle || ($urandom_range(0, 99) >= 36);
  end

  function automatic val_t rand_val();
    case ($urandom_range(0, 9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2, 3, 4: return {$urandom, $urandom};
      default: return val_t'($signed($urandom)) <<< $urandom_range(0, 24);
    endcase
  endfunction

  task automatic send_item(val_t k[9], val_t p);
    logic [IN_W-1:0] d;
    for (int i = 0; i < 9; i++) d[i*64 +: 64] = k[i];
    d[9*64 +: 64] = p;
    while (!no_idle && $urandom_range(0, 99) < 36) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    board.note_item(k, p);
  endtask

  task automatic send_random(int n);
    val_t k[9];
    for (int i = 0; i < n; i++) begin
      foreach (k[j]) k[j] = rand_val();
      send_item(k, rand_val());
    end
    in_tvalid <= 0;
  endtask

  task automatic write_reg(int idx, logic [63:0] v);
    cfg_psel <= 1;
    cfg_penable <= 0;
    cfg_pwrite <= 1;
    cfg_paddr <= CFG_ADDR_W'(idx * 8);
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    board.write_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic drain();
    while (board.rows_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_all(logic [63:0] c, logic [63:0] sn, logic [63:0] il,
                         logic [63:0] a, logic [63:0] b, logic [63:0] x, logic [63:0] y);
    write_reg(REG_COS, c);
    write_reg(REG_SIN, sn);
    write_reg(REG_INVL, il);
    write_reg(REG_OIX, a);
    write_reg(REG_OIY, b);
    write_reg(REG_OJX, x);
    write_reg(REG_OJY, y);
  endtask

  function automatic logic [63:0] small_off();
    return 64'($signed($urandom)) <<< $urandom_range(0, 6);
  endfunction

  initial begin
    val_t k[9];
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed, plain path at reset settings
    foreach (k[j]) k[j] = '0;
    send_item(k, '0);
    foreach (k[j]) k[j] = VAL_MAX;
    send_item(k, VAL_MAX);
    foreach (k[j]) k[j] = VAL_MIN;
    send_item(k, VAL_MIN);
    for (int f = 0; f < 9; f++) begin
      foreach (k[j]) k[j] = 64'sh1_0000_0000;
      k[f] = (f % 2) ? VAL_MIN : VAL_MAX;
      send_item(k, -64'sh3_0000_0000);
    end
    foreach (k[j]) k[j] = 64'sh2_8000_0000;
    send_item(k, VAL_MAX);
    send_item(k, VAL_MIN);
    send_random(6);
    drain();

    // rotated with offsets, spare register written too
    set_all(64'h0_B504_F334, 64'h0_B504_F334, 64'h0_4000_0000,
            small_off(), small_off(), small_off(), small_off());
    write_reg(REG_SPARE, 64'hDEAD_BEEF_0123_4567);
    send_random(90);
    drain();

    // extremes: full negative cosine, zero length reciprocal
    set_all(64'h3_0000_0000, 64'h1_0000_0000, 64'h0, VAL_MAX, VAL_MIN, VAL_MIN, VAL_MAX);
    send_random(40);
    drain();

    set_all(64'h1_0000_0000, 64'h3_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
            '0, '0, '0, '0);
    send_random(40);
    drain();

    // random settings, one phase without idling
    for (int ph = 0; ph < 6; ph++) begin
      set_all({$urandom, $urandom}, {$urandom, $urandom},
              ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                          : 64'($urandom) << $urandom_range(0, 4),
              small_off(), small_off(), {$urandom, $urandom}, small_off());
      no_idle = (ph == 2);
      send_random(50);
      drain();
    end
    no_idle = 0;

    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
